// ----- sv/nic_pkg.sv -----
// Package: constants, types and command/status structs of the normalized image convolution.
package nic_pkg;

  localparam int KernelMax = 7;
  localparam int LineMax   = 1024;
  localparam int HeightMax = 1024;
  localparam int CoefDepth = KernelMax * KernelMax;
  localparam int LineDepth = KernelMax * LineMax;

  localparam int KW   = 3;
  localparam int DW   = 11;
  localparam int PW   = 10;
  localparam int CIW  = 6;
  localparam int CVW  = 16;
  localparam int LAW  = 13;
  localparam int ACCW = 30;
  localparam int NW   = 22;

  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic [1:0] REG_KSIZE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic          coef_wr;
    logic          pix_wr;
    logic          norm_clr;
    logic          norm_add;
    logic          acc_clr;
    logic          mac_rd;
    logic          div_start;
    logic          out_load;
    logic [CIW-1:0] cidx;
    logic [LAW-1:0] laddr;
  } nic_cmd_t;

  typedef struct packed {
    logic div_done;
    logic norm_zero;
  } nic_sts_t;

endpackage

// ----- sv/nic_if.sv -----
// Valid/ready stream interfaces for the input requests and output pixels.
interface nic_in_if;
  import nic_pkg::*;
  logic           valid;
  logic           ready;
  logic           req_type;
  logic [CIW-1:0] coef_index;
  logic [CVW-1:0] coef_value;
  logic [7:0]     pix_red;
  logic [7:0]     pix_green;
  logic [7:0]     pix_blue;
  modport source (output valid, req_type, coef_index, coef_value, pix_red, pix_green,
                  pix_blue, input ready);
  modport sink (input valid, req_type, coef_index, coef_value, pix_red, pix_green,
                pix_blue, output ready);
endinterface

interface nic_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;
  logic       zero_norm;
  modport source (output valid, out_red, out_green, out_blue, frame_last, zero_norm,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_last, zero_norm,
                output ready);
endinterface

// ----- sv/nic_div.sv -----
// Serial restoring divider, three channels sharing one divisor, one quotient bit per cycle.
module nic_div import nic_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0][ACCW-1:0]  num_i,
  input  logic [NW-1:0]         den_i,
  output logic                  done_o,
  output logic [2:0][7:0]       quo_o
);
  localparam int CW = $clog2(ACCW + 1);

  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic [2:0][ACCW-1:0]      num_q, num_d;
  logic [2:0][ACCW-1:0]      quo_q, quo_d;
  logic [2:0][NW:0]          rem_q, rem_d;
  logic [NW-1:0]             den_q, den_d;

  always_comb begin
    logic [NW:0] trial;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(ACCW);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        trial = {rem_q[ch][NW-1:0], num_q[ch][ACCW-1]};
        num_d[ch] = {num_q[ch][ACCW-2:0], 1'b0};
        if (trial >= {1'b0, den_q}) begin
          rem_d[ch] = trial - {1'b0, den_q};
          quo_d[ch] = {quo_q[ch][ACCW-2:0], 1'b1};
        end else begin
          rem_d[ch] = trial;
          quo_d[ch] = {quo_q[ch][ACCW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CW'(1)) && !start_i;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      quo_o[ch] = (quo_d[ch] > ACCW'(255)) ? 8'hFF : quo_d[ch][7:0];
    end
  end

`ifndef SYNTHESIS
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with zero count");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("divider busy after done");
`endif
endmodule

// ----- sv/nic_datapath.sv -----
// Datapath: coefficient store, line memory, MAC accumulators, divider and output register.
module nic_datapath import nic_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nic_cmd_t        cmd_i,
  output nic_sts_t        sts_o,
  input  logic [CVW-1:0]  coef_value_i,
  input  logic [23:0]     pix_i,
  input  logic            last_i,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o,
  output logic            frame_last_o,
  output logic            zero_norm_o
);
  logic [CVW-1:0]       coef_q [CoefDepth];
  logic [CoefDepth-1:0] coef_vld_q;
  logic [23:0]          line_mem [LineDepth];
  logic [23:0]          pix_rd_q;
  logic [CVW-1:0]       coef_rd_q;
  logic [NW-1:0]        norm_q;
  logic                 norm_v_q;
  logic [2:0][ACCW-1:0] acc_q;
  logic [CVW+7:0]       prod_q [3];
  logic                 prod_v_q;
  logic                 last_q;
  logic [2:0][7:0]      quo;
  logic                 div_done;
  logic                 norm_zero;

  // unwritten coefficients read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (cmd_i.coef_wr) begin
      coef_vld_q[cmd_i.cidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr) coef_q[cmd_i.cidx] <= coef_value_i;
    coef_rd_q <= coef_vld_q[cmd_i.cidx] ? coef_q[cmd_i.cidx] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_wr) line_mem[cmd_i.laddr] <= pix_i;
    pix_rd_q <= line_mem[cmd_i.laddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_clr) norm_q <= '0;
    else if (norm_v_q) norm_q <= norm_q + NW'(coef_rd_q);
    for (int ch = 0; ch < 3; ch++) prod_q[ch] <= pix_rd_q[8*ch +: 8] * coef_rd_q;
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (prod_v_q) begin
      for (int ch = 0; ch < 3; ch++) acc_q[ch] <= acc_q[ch] + ACCW'(prod_q[ch]);
    end
    if (cmd_i.pix_wr) last_q <= last_i;
  end

  logic rd_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      norm_v_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.mac_rd;
      prod_v_q <= rd_v_q;
      norm_v_q <= cmd_i.norm_add;
    end
  end

  nic_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q),
    .den_i   (norm_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign norm_zero = (norm_q == '0);
  assign sts_o = '{div_done: div_done, norm_zero: norm_zero};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_red_o    <= norm_zero ? 8'd0 : quo[0];
      out_green_o  <= norm_zero ? 8'd0 : quo[1];
      out_blue_o   <= norm_zero ? 8'd0 : quo[2];
      frame_last_o <= last_q;
      zero_norm_o  <= norm_zero;
    end
  end
endmodule

// ----- sv/nic_ctrl.sv -----
// Controller: position tracking, window sequencing and handshake state machine.
module nic_ctrl import nic_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [KW-1:0]   ksize_i,
  input  logic [DW-1:0]   width_i,
  input  logic [DW-1:0]   height_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  logic [CIW-1:0]  coef_index_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nic_cmd_t        cmd_o,
  input  nic_sts_t        sts_i,
  output logic            last_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] row_q, row_d, col_q, col_d;
  logic [PW-1:0] c0_q, c0_d;
  logic [2:0]    rm_q, rm_d, rm0_q, rm0_d;
  logic [KW-1:0] kr_q, kr_d, kc_q, kc_d;
  logic [CIW-1:0] ci_q, ci_d;
  logic [1:0]    wt_q, wt_d;
  logic          ov_q, ov_d;
  logic [KW-1:0] k_q, k_d;

  logic [KW-1:0] k;
  logic [DW-1:0] w, h;
  logic [DW-1:0] r_cur, c_cur, rn;
  logic [2:0]    rm_cur, rm_nx;
  logic [3:0]    rs0;
  logic          accept, emit;
  logic [CIW-1:0] kk;
  logic [PW-1:0]  colsel;
  logic [2:0]     rmod;

  assign k = (ksize_i == '0) ? KW'(1) : ksize_i;
  assign w = (width_i == '0) ? DW'(1) : (width_i > DW'(LineMax)) ? DW'(LineMax) : width_i;
  assign h = (height_i == '0) ? DW'(1) : (height_i > DW'(HeightMax)) ? DW'(HeightMax)
           : height_i;

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign accept = in_valid_i && in_ready_o;

  // rm_q tracks row_q modulo KernelMax, the line memory slot of the row
  always_comb begin
    c_cur  = {1'b0, col_q};
    rn     = {1'b0, row_q};
    rm_cur = rm_q;
    if (c_cur >= w) begin
      c_cur  = '0;
      rn     = rn + 1'b1;
      rm_cur = (rm_q == 3'(KernelMax - 1)) ? '0 : rm_q + 1'b1;
    end
    if (rn >= h) begin
      r_cur  = '0;
      rm_cur = '0;
    end else begin
      r_cur  = rn;
    end
  end

  assign rm_nx = (rm_cur == 3'(KernelMax - 1)) ? '0 : rm_cur + 1'b1;
  assign rs0   = 4'(rm_cur) + 4'd8 - 4'(k);

  assign emit = (DW'(k) <= w) && (DW'(k) <= h) && (r_cur + 1'b1 >= DW'(k))
              && (c_cur + 1'b1 >= DW'(k));
  assign kk = CIW'(k_q) * CIW'(k_q);
  assign last_o = (r_cur == h - 1'b1) && (c_cur == w - 1'b1);

  always_comb begin
    logic [3:0] rs;
    rs     = 4'(rm0_q) + 4'(kr_q);
    rmod   = (rs >= 4'(KernelMax)) ? 3'(rs - 4'(KernelMax)) : rs[2:0];
    colsel = c0_q + PW'(kc_q);
  end

  always_comb begin
    state_d = state_q;
    row_d = row_q; col_d = col_q; rm_d = rm_q; rm0_d = rm0_q; c0_d = c0_q;
    kr_d = kr_q; kc_d = kc_q; ci_d = ci_q; wt_d = wt_q; ov_d = ov_q; k_d = k_q;
    cmd_o = '0;
    cmd_o.cidx  = ci_q;
    cmd_o.laddr = LAW'(rmod) * LAW'(LineMax) + LAW'(colsel);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && req_type_i == REQ_COEF) begin
          cmd_o.cidx = coef_index_i;
          cmd_o.coef_wr = (coef_index_i < CIW'(CoefDepth));
        end else if (accept) begin
          cmd_o.pix_wr = 1'b1;
          cmd_o.laddr = LAW'(rm_cur) * LAW'(LineMax) + LAW'(c_cur);
          rm0_d = (rs0 >= 4'(KernelMax)) ? 3'(rs0 - 4'(KernelMax)) : rs0[2:0];
          c0_d = PW'(c_cur + 1'b1 - DW'(k));
          k_d = k;
          if (c_cur + 1'b1 >= w) begin
            col_d = '0;
            row_d = (r_cur + 1'b1 >= h) ? '0 : PW'(r_cur + 1'b1);
            rm_d  = (r_cur + 1'b1 >= h) ? '0 : rm_nx;
          end else begin
            col_d = PW'(c_cur + 1'b1);
            row_d = PW'(r_cur);
            rm_d  = rm_cur;
          end
          if (emit) begin
            cmd_o.norm_clr = 1'b1;
            cmd_o.acc_clr = 1'b1;
            ci_d = '0;
            kr_d = '0;
            kc_d = '0;
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        cmd_o.norm_add = 1'b1;
        if (ci_q == kk - 1'b1) begin
          ci_d = '0;
          state_d = S_MAC;
        end else ci_d = ci_q + 1'b1;
      end
      S_MAC: begin
        cmd_o.mac_rd = 1'b1;
        ci_d = ci_q + 1'b1;
        if (kc_q == k_q - 1'b1) begin
          kc_d = '0;
          if (kr_q == k_q - 1'b1) begin
            wt_d = '0;
            state_d = S_WAIT;
          end else kr_d = kr_q + 1'b1;
        end else kc_d = kc_q + 1'b1;
      end
      S_WAIT: begin
        wt_d = wt_q + 1'b1;
        if (wt_q == 2'd2) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q <= '0; col_q <= '0; rm_q <= '0; rm0_q <= '0; c0_q <= '0;
      kr_q <= '0; kc_q <= '0; ci_q <= '0; wt_q <= '0; ov_q <= 1'b0; k_q <= KW'(1);
    end else begin
      state_q <= state_d;
      row_q <= row_d; col_q <= col_d; rm_q <= rm_d; rm0_q <= rm0_d; c0_q <= c0_d;
      kr_q <= kr_d; kc_q <= kc_d; ci_q <= ci_d; wt_q <= wt_d; ov_q <= ov_d; k_q <= k_d;
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_busy_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("ready while busy");
  a_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !ov_q) else $error("overwrote pending result");
`endif
endmodule

// ----- sv/normalized_image_convolution.sv -----
// Top level: APB register file, controller and datapath of the normalized convolution.
//  channel | direction | handshake
//  in_if   | sink      | valid/ready, coefficient write or pixel
//  out_if  | source    | valid/ready, one output pixel
//  apb     | slave     | psel/penable/pwrite, pready tied high
// A coefficient write or a pixel without a window leaves the controller in its idle state.
// A window runs the K*K norm sum, the K*K MAC reads, a wait state and the divider.
// The divider is serial and makes one quotient bit per cycle.
// Reset loads register defaults, clears kernel store and position, not the line memory.
// A result waits in the output register; a new item is taken once it has left.
module normalized_image_convolution import nic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nic_in_if.sink      in_if,
  nic_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [KW-1:0] ksize_q;
  logic [DW-1:0] width_q, height_q;
  logic          wr;
  nic_cmd_t      cmd;
  nic_sts_t      sts;
  logic          last;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q  <= KW'(3);
      width_q  <= DW'(1024);
      height_q <= DW'(1024);
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_KSIZE:  ksize_q  <= pwdata[KW-1:0];
        REG_WIDTH:  width_q  <= pwdata[DW-1:0];
        REG_HEIGHT: height_q <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KSIZE:  prdata = 32'(ksize_q);
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  nic_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ksize_i      (ksize_q),
    .width_i      (width_q),
    .height_i     (height_q),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .req_type_i   (in_if.req_type),
    .coef_index_i (in_if.coef_index),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .cmd_o        (cmd),
    .sts_i        (sts),
    .last_o       (last)
  );

  nic_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .coef_value_i (in_if.coef_value),
    .pix_i        ({in_if.pix_blue, in_if.pix_green, in_if.pix_red}),
    .last_i       (last),
    .out_red_o    (out_if.out_red),
    .out_green_o  (out_if.out_green),
    .out_blue_o   (out_if.out_blue),
    .frame_last_o (out_if.frame_last),
    .zero_norm_o  (out_if.zero_norm)
  );
endmodule
